// File: sv/rflc_pkg.sv
package rflc_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;
	localparam int COORD_W = 32;
	localparam int REGION_SHIFT = 5;
	localparam int KEY_W = COORD_W - REGION_SHIFT;
	localparam int SLOT_OUT_W = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FRONT
	} state_t;

endpackage

// File: sv/rflc_ram.sv
module rflc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/region_file_lru_cache.sv
// Sequence: a lookup walks the list in ST_SCAN until a match or the last entry; an empty
// cache skips it, a non-full miss passes ST_TAIL, then ST_FRONT raises the done strobe.
// Throughput: one transaction at a time; start may be taken in the strobe cycle.
// The list walk compares one entry per cycle through a single key comparator and RAM port.
// Reset empties the cache; the list RAM is not cleared, since the entry count guards it.
// Results are valid for the single strobe cycle only; the receiver cannot stall.
module region_file_lru_cache
	import rflc_pkg::*;
#(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [COORD_W-1:0] chunk_x,
	input  logic signed [COORD_W-1:0] chunk_z,
	output logic                    done,
	output logic                    hit,
	output logic [SLOT_OUT_W-1:0]   slot,
	output logic signed [KEY_W-1:0] region_x,
	output logic signed [KEY_W-1:0] region_z,
	output logic                    evicted,
	output logic signed [KEY_W-1:0] evicted_x,
	output logic signed [KEY_W-1:0] evicted_z
);

	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int SLOT_W = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
	localparam int ENTRY_W = 2 * KEY_W + SLOT_W;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic done_q;

	logic [IDX_W-1:0] idx_q;
	logic [KEY_W-1:0] key_x_q, key_z_q;
	logic [ENTRY_W-1:0] carry_q;
	logic [SLOT_W-1:0] slot_q;
	logic hit_q, ev_q;
	logic [KEY_W-1:0] evx_q, evz_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic [KEY_W-1:0] rd_x, rd_z;
	logic [SLOT_W-1:0] rd_slot;
	logic match, last, full;

	rflc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CACHE_ENTRIES)
	) u_list (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_x = ram_rdata[ENTRY_W-1 -: KEY_W];
	assign rd_z = ram_rdata[SLOT_W +: KEY_W];
	assign rd_slot = ram_rdata[SLOT_W-1:0];

	assign match = (rd_x == key_x_q) && (rd_z == key_z_q);
	assign last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign full = count_q == CNT_W'(CACHE_ENTRIES);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (count_q == '0) ? ST_FRONT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = ST_FRONT;
				end else if (last) begin
					state_d = full ? ST_FRONT : ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_FRONT;
			ST_FRONT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = carry_q;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: ram_raddr = '0;
			ST_SCAN: begin
				ram_raddr = idx_q + IDX_W'(1);
				ram_we = idx_q != '0;
				ram_waddr = idx_q;
			end
			ST_TAIL: begin
				ram_we = 1'b1;
				ram_waddr = count_q[IDX_W-1:0];
			end
			ST_FRONT: begin
				ram_we = 1'b1;
				ram_waddr = '0;
				ram_wdata = {key_x_q, key_z_q, slot_q};
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= state_q == ST_FRONT;
			if (state_q == ST_FRONT && !hit_q && !ev_q) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_x_q <= chunk_x[COORD_W-1:REGION_SHIFT];
					key_z_q <= chunk_z[COORD_W-1:REGION_SHIFT];
					idx_q <= '0;
					slot_q <= '0;
					hit_q <= 1'b0;
					ev_q <= 1'b0;
					evx_q <= '0;
					evz_q <= '0;
				end
			end
			ST_SCAN: begin
				carry_q <= ram_rdata;
				idx_q <= idx_q + IDX_W'(1);
				if (match) begin
					hit_q <= 1'b1;
					slot_q <= rd_slot;
				end else if (last) begin
					if (full) begin
						ev_q <= 1'b1;
						evx_q <= rd_x;
						evz_q <= rd_z;
						slot_q <= rd_slot;
					end else begin
						slot_q <= SLOT_W'(count_q[IDX_W-1:0]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign hit = hit_q;
	assign slot = slot_q[SLOT_OUT_W-1:0];
	assign region_x = key_x_q;
	assign region_z = key_z_q;
	assign evicted = ev_q;
	assign evicted_x = evx_q;
	assign evicted_z = evz_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("Result strobe while the sequencer is still busy.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CACHE_ENTRIES))
		else $error("Entry count exceeds the cache size.");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted))
		else $error("A transaction reported both a hit and an eviction.");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> full)
		else $error("Eviction reported while the cache was not full.");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRONT && !hit_q && !ev_q) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("A miss without eviction did not add an entry.");

endmodule

// File: test/region_file_lru_cache_test.sv
module region_file_lru_cache_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rflc_pkg::*;

	typedef struct {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cz;
		int unsigned        idle_pct;
		bit                 drain_first;
	} chunk_request_t;

	typedef struct {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
		logic [KEY_W-1:0]      rx;
		logic [KEY_W-1:0]      rz;
		logic                  ev;
		logic [KEY_W-1:0]      ex;
		logic [KEY_W-1:0]      ez;
	} lookup_result_t;

	localparam int POOL_SIZE = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [COORD_W-1:0] chunk_x = '0;
	logic signed [COORD_W-1:0] chunk_z = '0;
	logic busy;
	logic done;
	logic hit;
	logic [SLOT_OUT_W-1:0] slot;
	logic signed [KEY_W-1:0] region_x;
	logic signed [KEY_W-1:0] region_z;
	logic evicted;
	logic signed [KEY_W-1:0] evicted_x;
	logic signed [KEY_W-1:0] evicted_z;

	chunk_request_t pending_requests[$];
	lookup_result_t expected_lookups[$];

	logic [KEY_W-1:0]      lru_key_x[CACHE_ENTRIES_DEF];
	logic [KEY_W-1:0]      lru_key_z[CACHE_ENTRIES_DEF];
	logic [SLOT_OUT_W-1:0] lru_slot[CACHE_ENTRIES_DEF];
	int                    lru_count = 0;

	logic [KEY_W-1:0] pool_x[POOL_SIZE];
	logic [KEY_W-1:0] pool_z[POOL_SIZE];

	int mismatch_count = 0;
	int lookups_seen = 0;
	int hits_seen = 0;
	int evictions_seen = 0;

	region_file_lru_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.chunk_x   (chunk_x),
		.chunk_z   (chunk_z),
		.done      (done),
		.hit       (hit),
		.slot      (slot),
		.region_x  (region_x),
		.region_z  (region_z),
		.evicted   (evicted),
		.evicted_x (evicted_x),
		.evicted_z (evicted_z)
	);

	always #5 clk = ~clk;

	function automatic lookup_result_t predict_lookup(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cz);
		lookup_result_t r;
		logic [KEY_W-1:0] kx;
		logic [KEY_W-1:0] kz;
		int pos;
		int last;
		kx = cx[COORD_W-1:REGION_SHIFT];
		kz = cz[COORD_W-1:REGION_SHIFT];
		r = '{default: '0};
		r.rx = kx;
		r.rz = kz;
		pos = -1;
		for (int i = 0; i < lru_count; i++) begin
			if (pos < 0 && lru_key_x[i] == kx && lru_key_z[i] == kz)
				pos = i;
		end
		if (pos >= 0) begin
			r.hit = 1'b1;
			r.slot = lru_slot[pos];
			last = pos;
		end else if (lru_count < CACHE_ENTRIES_DEF) begin
			r.slot = SLOT_OUT_W'(lru_count);
			last = lru_count;
			lru_count++;
		end else begin
			last = CACHE_ENTRIES_DEF - 1;
			r.ev = 1'b1;
			r.ex = lru_key_x[last];
			r.ez = lru_key_z[last];
			r.slot = lru_slot[last];
		end
		for (int i = last; i > 0; i--) begin
			lru_key_x[i] = lru_key_x[i-1];
			lru_key_z[i] = lru_key_z[i-1];
			lru_slot[i] = lru_slot[i-1];
		end
		lru_key_x[0] = kx;
		lru_key_z[0] = kz;
		lru_slot[0] = r.slot;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] lookup %0d: %s", $realtime, lookups_seen, what);
		mismatch_count++;
	endtask

	task automatic add_request(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cz,
			input int unsigned idle_pct, input bit drain_first);
		chunk_request_t req;
		req.cx = cx;
		req.cz = cz;
		req.idle_pct = idle_pct;
		req.drain_first = drain_first;
		pending_requests.insert(pending_requests.size(), req);
	endtask

	// Most requests land on a pooled set of regions so that hits, deep hits and
	// evictions all happen; the rest are arbitrary coordinates.
	task automatic add_random_request(input int unsigned idle_pct, input bit drain_first);
		int unsigned pick;
		int unsigned k;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cz;
		pick = $urandom_range(99);
		if (pick < 85) begin
			k = (pick < 55) ? $urandom_range(11) : $urandom_range(POOL_SIZE - 1);
			cx = {pool_x[k], REGION_SHIFT'($urandom_range(31))};
			cz = {pool_z[k], REGION_SHIFT'($urandom_range(31))};
		end else begin
			cx = $urandom;
			cz = $urandom;
		end
		add_request(cx, cz, idle_pct, drain_first);
	endtask

	always @(posedge clk) begin : driver
		chunk_request_t req;
		bit taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken)
				expected_lookups.insert(expected_lookups.size(),
					predict_lookup(chunk_x, chunk_z));
			if (!start || taken) begin
				if (pending_requests.size() > 0
						&& !(pending_requests[0].drain_first && expected_lookups.size() > 0)
						&& $urandom_range(99) >= pending_requests[0].idle_pct) begin
					req = pending_requests.pop_front();
					start <= 1'b1;
					chunk_x <= req.cx;
					chunk_z <= req.cz;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		lookup_result_t want;
		if (arst_n && done) begin
			if (expected_lookups.size() == 0) begin
				report_mismatch("result strobe with no transaction outstanding");
			end else begin
				want = expected_lookups.pop_front();
				if (hit !== want.hit)
					report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
				if (slot !== want.slot)
					report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
				if (region_x !== want.rx)
					report_mismatch($sformatf("region_x %h, expected %h", region_x, want.rx));
				if (region_z !== want.rz)
					report_mismatch($sformatf("region_z %h, expected %h", region_z, want.rz));
				if (evicted !== want.ev)
					report_mismatch($sformatf("evicted %b, expected %b", evicted, want.ev));
				if (evicted_x !== want.ex)
					report_mismatch($sformatf("evicted_x %h, expected %h", evicted_x, want.ex));
				if (evicted_z !== want.ez)
					report_mismatch($sformatf("evicted_z %h, expected %h", evicted_z, want.ez));
				hits_seen += want.hit;
				evictions_seen += want.ev;
			end
			lookups_seen++;
		end
	end

	initial begin
		#5ms;
		$display("Run timed out with %0d transactions still queued.", pending_requests.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_x[i] = KEY_W'($urandom);
			pool_z[i] = KEY_W'($urandom);
		end
		pool_x[0] = {1'b1, {(KEY_W-1){1'b0}}};
		pool_z[0] = {1'b0, {(KEY_W-1){1'b1}}};
		pool_x[1] = '1;
		pool_z[1] = '0;

		add_request(32'd0, 32'd0, 35, 1'b0);
		add_request(32'd31, 32'd31, 35, 1'b0);
		add_request(32'hFFFFFFFF, 32'hFFFFFFFF, 35, 1'b0);
		add_request(-32'sd32, -32'sd32, 35, 1'b0);
		add_request(-32'sd33, 32'd32, 35, 1'b0);
		add_request(32'h80000000, 32'h7FFFFFFF, 35, 1'b0);
		add_request(32'h7FFFFFFF, 32'h80000000, 35, 1'b0);
		add_request(32'd0, 32'd5, 35, 1'b0);
		for (int k = 1; k <= 13; k++)
			add_request(k * 37 * 32, -k * 5 * 32, 35, 1'b0);
		add_request(-32'sd33, 32'd63, 35, 1'b0);

		for (int i = 0; i < 130; i++)
			add_random_request(35, $urandom_range(49) == 0);
		for (int i = 0; i < 135; i++)
			add_random_request(55, i == 0 || $urandom_range(49) == 0);
		for (int i = 0; i < 135; i++)
			add_random_request(0, i == 0 || $urandom_range(49) == 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() > 0 || start)
			@(posedge clk);
		while (expected_lookups.size() > 0)
			@(posedge clk);
		repeat (CACHE_ENTRIES_DEF + 4) @(posedge clk);

		$display("Checked %0d lookups: %0d hits, %0d misses, %0d of them evicting.",
			lookups_seen, hits_seen, lookups_seen - hits_seen, evictions_seen);
		$display("Traffic ran under three sender idle rates with drain pauses in between.");
		if (mismatch_count == 0 && expected_lookups.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
sv/rflc_pkg.sv
sv/rflc_ram.sv
sv/region_file_lru_cache.sv
test/region_file_lru_cache_test.sv
